// File: sv/imu_uart_response_parser_macros.svh
// Assertion macros for the IMU UART response parser.
// Needs i_clk and i_rst_n in the scope where a macro is used.
`ifndef IMU_UART_RESPONSE_PARSER_MACROS_SVH
`define IMU_UART_RESPONSE_PARSER_MACROS_SVH

// Checked while out of reset.
`define IURP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error(msg);

// Checked on every edge, reset included.
`define IURP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error(msg);

`endif

// File: sv/iurp_pkg.sv
// Types and constants of the IMU UART response parser.
// No dependencies; used by the channel interfaces and the top level.
`timescale 1ns / 1ps

package iurp_pkg;

    typedef logic [7:0]  t_byte;
    typedef logic [2:0]  t_event;
    typedef logic [8:0]  t_pos;

    // frame headers and status
    localparam t_byte HDR_ACK    = 8'hEE;
    localparam t_byte HDR_READ   = 8'hBB;
    localparam t_byte ACK_OK     = 8'h01;
    localparam t_byte ORIENT_LEN = 8'd6;

    // result event codes
    localparam t_event EV_MID    = 3'd0;
    localparam t_event EV_WOK    = 3'd1;
    localparam t_event EV_WERR   = 3'd2;
    localparam t_event EV_READ   = 3'd3;
    localparam t_event EV_ORIENT = 3'd4;
    localparam t_event EV_DROP   = 3'd5;

    typedef struct packed {
        t_event             event_res;
        t_byte              ack_status;
        t_byte              read_length;
        t_byte              first_data;
        logic signed [15:0] heading_raw;
        logic signed [15:0] pitch_raw;
        logic signed [15:0] roll_raw;
    } t_res;

endpackage

// File: sv/iurp_if.sv
// Valid/ready channel interfaces of the IMU UART response parser.
// Depends on iurp_pkg.
`timescale 1ns / 1ps

interface iurp_byte_if import iurp_pkg::*; ();
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface iurp_res_if import iurp_pkg::*; ();
    logic               valid;
    logic               ready;
    t_event             event_res;
    t_byte              ack_status;
    t_byte              read_length;
    t_byte              first_data;
    logic signed [15:0] heading_raw;
    logic signed [15:0] pitch_raw;
    logic signed [15:0] roll_raw;

    modport source (output valid, output event_res, output ack_status, output read_length,
                    output first_data, output heading_raw, output pitch_raw,
                    output roll_raw, input ready);
    modport sink   (input valid, input event_res, input ack_status, input read_length,
                    input first_data, input heading_raw, input pitch_raw,
                    input roll_raw, output ready);
endinterface

// File: sv/imu_uart_response_parser.sv
// Each accepted byte gives one result item from the result register.
// Throughput: one byte per cycle unless stalled; a stall only backs up through
//   the input and result registers, so one more byte is taken while a result waits.
// Reset: i_rst_n synchronous, active low; clears both valid flags and the frame
//   state. The data buffer is not cleared; every read of it hits a byte of this frame.
// Depends on iurp_pkg, iurp_if and imu_uart_response_parser_macros.svh.
`timescale 1ns / 1ps
`include "imu_uart_response_parser_macros.svh"

module imu_uart_response_parser import iurp_pkg::*; #(
    parameter int DATA_BYTES = 6    // stored data bytes of a read response, 6..32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    iurp_byte_if.sink     i_rx,
    iurp_res_if.source    o_res
);

    localparam int IDX_W = $clog2(DATA_BYTES);

    // ---------------------------------------------------------------
    // Handshake: input register -> decode -> result register.
    // The decode stage advances whenever the result register is empty
    // or being drained, so a byte can enter every cycle.
    // ---------------------------------------------------------------
    logic   r_in_valid;
    t_byte  r_in_byte;
    logic   r_out_valid;
    t_res   r_res;

    logic   s_adv;       // result register can take a new item
    logic   s_in_ready;  // input register can take a new byte
    logic   s_fire;      // decode stage hands an item on

    assign s_adv      = !r_out_valid || o_res.ready;
    assign s_in_ready = !r_in_valid || s_adv;
    assign s_fire     = r_in_valid && s_adv;
    assign i_rx.ready = s_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_in_ready) begin
            r_in_valid <= i_rx.valid;
        end
        if (s_in_ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // ---------------------------------------------------------------
    // Frame state.
    //   r_pos   : 0 = waiting for header, 1 = status/length byte,
    //             2.. = data bytes (data index = r_pos - 2)
    //   r_hdr   : header of the current frame
    //   r_len   : data length of the read response
    //   r_in_rd : read response in progress
    // ---------------------------------------------------------------
    t_pos   r_pos,   n_pos;
    t_byte  r_hdr,   n_hdr;
    t_byte  r_len,   n_len;
    logic   r_in_rd, n_in_rd;
    t_byte  r_data [DATA_BYTES];

    t_res   n_res;
    logic   s_wr_en;
    t_pos   s_didx;

    assign s_didx = r_pos - 9'd2;

    always_comb begin
        n_pos   = r_pos;
        n_hdr   = r_hdr;
        n_len   = r_len;
        n_in_rd = r_in_rd;
        n_res   = '0;
        s_wr_en = 1'b0;

        if (r_pos == 9'd0) begin
            // header byte: anything but the two known headers is dropped
            n_hdr = r_in_byte;
            if (r_in_byte inside {HDR_ACK, HDR_READ}) begin
                n_pos           = 9'd1;
                n_res.event_res = EV_MID;
            end else begin
                n_res.event_res = EV_DROP;
            end
        end else if (r_pos == 9'd1) begin
            if (r_hdr == HDR_ACK) begin
                // write acknowledgement: the status byte ends the frame
                n_res.event_res  = (r_in_byte == ACK_OK) ? EV_WOK : EV_WERR;
                n_res.ack_status = r_in_byte;
                n_pos            = '0;
                n_in_rd          = 1'b0;
                n_len            = '0;
            end else if (r_hdr == HDR_READ) begin
                if (r_in_byte == 8'd0) begin
                    // empty read completes on its length byte
                    n_res.event_res = EV_READ;
                    n_pos           = '0;
                    n_in_rd         = 1'b0;
                    n_len           = '0;
                end else begin
                    n_len           = r_in_byte;
                    n_in_rd         = 1'b1;
                    n_pos           = 9'd2;
                    n_res.event_res = EV_MID;
                end
            end else begin
                // cannot happen from a clean start; resync
                n_pos   = '0;
                n_in_rd = 1'b0;
                n_len   = '0;
            end
        end else if (!r_in_rd) begin
            // data position without a read in progress; resync
            n_pos   = '0;
            n_in_rd = 1'b0;
            n_len   = '0;
        end else begin
            // data byte; bytes past the buffer are only counted
            s_wr_en = (s_didx < 9'(DATA_BYTES));
            if (r_pos >= ({1'b0, r_len} + 9'd1)) begin
                n_res.event_res   = (r_len == ORIENT_LEN) ? EV_ORIENT : EV_READ;
                n_res.read_length = r_len;
                // a one-byte read has its first byte arriving right now
                n_res.first_data  = (s_didx == 9'd0) ? r_in_byte : r_data[0];
                if (r_len == ORIENT_LEN) begin
                    // last byte of a 6-byte read is the roll high byte
                    n_res.heading_raw = {r_data[1], r_data[0]};
                    n_res.pitch_raw   = {r_data[3], r_data[2]};
                    n_res.roll_raw    = {r_in_byte, r_data[4]};
                end
                n_pos   = '0;
                n_in_rd = 1'b0;
                n_len   = '0;
            end else begin
                n_pos           = r_pos + 9'd1;
                n_res.event_res = EV_MID;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_hdr   <= '0;
            r_len   <= '0;
            r_in_rd <= 1'b0;
        end else if (s_fire) begin
            r_pos   <= n_pos;
            r_hdr   <= n_hdr;
            r_len   <= n_len;
            r_in_rd <= n_in_rd;
        end
    end

    // data buffer, written at the current data index
    always_ff @(posedge i_clk) begin
        if (s_fire && s_wr_en) begin
            r_data[s_didx[IDX_W-1:0]] <= r_in_byte;
        end
    end

    // ---------------------------------------------------------------
    // Result register
    // ---------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s_adv) begin
            r_out_valid <= r_in_valid;
        end
        if (s_fire) begin
            r_res <= n_res;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.event_res   = r_res.event_res;
    assign o_res.ack_status  = r_res.ack_status;
    assign o_res.read_length = r_res.read_length;
    assign o_res.first_data  = r_res.first_data;
    assign o_res.heading_raw = r_res.heading_raw;
    assign o_res.pitch_raw   = r_res.pitch_raw;
    assign o_res.roll_raw    = r_res.roll_raw;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    logic s_non_orient;    // held result item is valid and not an orientation read
    logic s_non_ack;       // held result item is valid and not a write acknowledgement
    logic s_angles_zero;   // all three angle fields are zero
    logic s_pos_in_frame;  // data position lies inside the read frame
    logic s_idle;          // nothing in flight, parser at frame start

    assign s_non_orient   = r_out_valid && (r_res.event_res != EV_ORIENT);
    assign s_non_ack      = r_out_valid && (r_res.event_res != EV_WOK)
                            && (r_res.event_res != EV_WERR);
    assign s_angles_zero  = (r_res.heading_raw == 16'sd0) && (r_res.pitch_raw == 16'sd0)
                            && (r_res.roll_raw == 16'sd0);
    assign s_pos_in_frame = (r_pos >= 9'd2) && (r_pos <= ({1'b0, r_len} + 9'd1));
    assign s_idle         = !r_out_valid && !r_in_valid && (r_pos == 9'd0);

    `IURP_ASSERT(a_read_hdr, (r_in_rd |-> r_hdr == HDR_READ), "read without read header")
    `IURP_ASSERT(a_pos_bound, (r_in_rd |-> s_pos_in_frame), "data position out of frame")
    `IURP_ASSERT(a_orient_only, (s_non_orient |-> s_angles_zero), "angles on plain item")
    `IURP_ASSERT(a_ack_only, (s_non_ack |-> r_res.ack_status == 8'd0), "status on non-ack item")
    `IURP_ASSERT_ALWAYS(a_rst_idle, (!i_rst_n |=> s_idle), "pipeline not idle after reset")

endmodule

// File: sim/imu_uart_response_parser_tb.sv
// Self-checking testbench for imu_uart_response_parser: byte frames in, one checked result per byte.
// Depends on iurp_pkg, iurp_if and the parser RTL; a scoreboard class predicts each result item.
`timescale 1ns / 1ps

module imu_uart_response_parser_tb;
    import iurp_pkg::*;

    localparam int STORE_BYTES = 6;        // data bytes the parser keeps
    localparam int HOLD_CYCLES = 120;      // long receiver hold-off
    localparam int SETTLE      = 8;        // settle time after the last result item is in

    // Frame decoder mirror plus the queue of result items still due.
    class frame_scoreboard;
        t_pos      pos;
        t_byte     hdr;
        t_byte     exp_len;
        bit        in_read;
        t_byte     store [STORE_BYTES];
        t_res      results_due [$];
        int        errors;

        function new();
            pos     = '0;
            hdr     = '0;
            exp_len = '0;
            in_read = 1'b0;
            errors  = 0;
            foreach (store[i]) store[i] = '0;
        endfunction

        function void end_frame();
            pos     = '0;
            in_read = 1'b0;
            exp_len = '0;
        endfunction

        // Decode one accepted byte and queue the result item it causes.
        function void take_rx_byte(t_byte b);
            t_res r;
            int   d;
            r = '0;
            if (pos == 0) begin
                hdr = b;
                if (b == HDR_ACK || b == HDR_READ) begin
                    pos         = 9'd1;
                    r.event_res = EV_MID;
                end else begin
                    r.event_res = EV_DROP;
                end
            end else if (pos == 1) begin
                if (hdr == HDR_ACK) begin
                    r.event_res  = (b == ACK_OK) ? EV_WOK : EV_WERR;
                    r.ack_status = b;
                    end_frame();
                end else if (hdr == HDR_READ) begin
                    exp_len = b;
                    in_read = 1'b1;
                    if (b == 0) begin
                        r.event_res = EV_READ;
                        end_frame();
                    end else begin
                        pos         = 9'd2;
                        r.event_res = EV_MID;
                    end
                end else begin
                    end_frame();
                end
            end else if (!in_read) begin
                end_frame();
            end else begin
                d = int'(pos) - 2;
                if (d < STORE_BYTES) store[d] = b;
                if (int'(pos) >= int'(exp_len) + 1) begin
                    r.event_res   = (exp_len == ORIENT_LEN) ? EV_ORIENT : EV_READ;
                    r.read_length = exp_len;
                    r.first_data  = store[0];
                    if (exp_len == ORIENT_LEN) begin
                        r.heading_raw = {store[1], store[0]};
                        r.pitch_raw   = {store[3], store[2]};
                        r.roll_raw    = {store[5], store[4]};
                    end
                    end_frame();
                end else begin
                    pos         = pos + 9'd1;
                    r.event_res = EV_MID;
                end
            end
            results_due.push_back(r);
        endfunction

        function void cmp_field(string name, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s expected %h got %h", $realtime, name, want, got);
                errors++;
            end
        endfunction

        // Compare an accepted result item with the oldest one due.
        function void check_result(t_res got);
            t_res want;
            if (results_due.size() == 0) begin
                $display("%0t: unexpected result item, expected none got %p", $realtime, got);
                errors++;
                return;
            end
            want = results_due.pop_front();
            cmp_field("event_res",   16'(want.event_res),   16'(got.event_res));
            cmp_field("ack_status",  16'(want.ack_status),  16'(got.ack_status));
            cmp_field("read_length", 16'(want.read_length), 16'(got.read_length));
            cmp_field("first_data",  16'(want.first_data),  16'(got.first_data));
            cmp_field("heading_raw", want.heading_raw,      got.heading_raw);
            cmp_field("pitch_raw",   want.pitch_raw,        got.pitch_raw);
            cmp_field("roll_raw",    want.roll_raw,         got.roll_raw);
        endfunction

        function int pending();
            return results_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    iurp_byte_if rx_if ();
    iurp_res_if  res_if ();

    imu_uart_response_parser dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_rx    (rx_if.sink),
        .o_res   (res_if.source)
    );

    frame_scoreboard sb = new();

    bit tx_idle;          // sender inserts gaps
    bit rx_idle;          // receiver inserts stalls
    bit hold_req;         // ask the receiver for one long hold-off
    int hold_left;
    int run_left;
    int off_left;
    int bytes_sent;

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Mostly back to back, some short gaps, a few long ones.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 50);
    endfunction

    // Receiver: one ready decision per cycle, long hold-off counted here.
    initial begin
        res_if.ready = 1'b0;
        hold_left = 0;
        run_left  = 0;
        off_left  = 0;
        forever @(posedge clk) begin
            if (hold_left > 0) begin
                res_if.ready <= 1'b0;
                hold_left--;
            end else if (hold_req) begin
                hold_req      = 1'b0;
                hold_left     = HOLD_CYCLES - 1;
                res_if.ready <= 1'b0;
            end else if (run_left > 0) begin
                res_if.ready <= 1'b1;
                run_left--;
            end else if (off_left > 0) begin
                res_if.ready <= 1'b0;
                off_left--;
            end else begin
                run_left      = $urandom_range(0, 15);
                off_left      = rx_idle ? pick_gap() : 0;
                res_if.ready <= 1'b1;
            end
        end
    end

    // Monitors sample pre-edge values, so driver ordering does not matter.
    always @(posedge clk) begin
        t_res got;
        if (rst_n) begin
            if (rx_if.valid && rx_if.ready)
                sb.take_rx_byte(rx_if.rx_byte);
            if (res_if.valid && res_if.ready) begin
                got.event_res   = res_if.event_res;
                got.ack_status  = res_if.ack_status;
                got.read_length = res_if.read_length;
                got.first_data  = res_if.first_data;
                got.heading_raw = res_if.heading_raw;
                got.pitch_raw   = res_if.pitch_raw;
                got.roll_raw    = res_if.roll_raw;
                sb.check_result(got);
            end
        end
    end

    // Offer one byte, wait for it to be taken, then maybe idle.
    task automatic put_byte(t_byte b);
        int g;
        rx_if.valid   <= 1'b1;
        rx_if.rx_byte <= b;
        do @(posedge clk); while (!rx_if.ready);
        bytes_sent++;
        g = tx_idle ? pick_gap() : 0;
        if (g > 0) begin
            rx_if.valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic put_read(int len);
        put_byte(HDR_READ);
        put_byte(t_byte'(len));
        repeat (len) put_byte(t_byte'($urandom()));
    endtask

    // Sender pauses until every due result item is in, then a short settle.
    task automatic drain();
        rx_if.valid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    // Mostly well-formed frames with random content, some noise and truncation.
    task automatic put_random_frame();
        int r;
        int len;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            put_byte(HDR_ACK);
            put_byte($urandom_range(0, 1) ? ACK_OK : t_byte'($urandom()));
        end else if (r < 55) begin
            put_read(ORIENT_LEN);
        end else if (r < 75) begin
            put_read($urandom_range(0, 12));
        end else if (r < 80) begin
            put_read($urandom_range(7, 40));
        end else if (r < 90) begin
            put_byte(t_byte'($urandom()));
        end else begin
            // header and length, then cut short; the next frame lands as data
            len = $urandom_range(2, 10);
            put_byte(HDR_READ);
            put_byte(t_byte'(len));
            repeat ($urandom_range(0, len - 1)) put_byte(t_byte'($urandom()));
        end
    endtask

    task automatic run_random(int n);
        int stop_at;
        stop_at = bytes_sent + n;
        while (bytes_sent < stop_at) put_random_frame();
    endtask

    initial begin
        rst_n         = 1'b0;
        rx_if.valid   = 1'b0;
        rx_if.rx_byte = '0;
        tx_idle       = 1'b0;
        rx_idle       = 1'b0;
        hold_req      = 1'b0;
        bytes_sent    = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: acks, unknown headers, zero length, short read, extreme angles
        put_byte(HDR_ACK);  put_byte(ACK_OK);
        put_byte(HDR_ACK);  put_byte(8'h00);
        put_byte(HDR_ACK);  put_byte(8'hFF);
        put_byte(8'h00);
        put_byte(8'hFF);
        put_byte(8'h55);
        put_byte(HDR_READ); put_byte(8'h00);
        put_byte(HDR_READ); put_byte(8'h01); put_byte(8'hA5);
        put_byte(HDR_READ); put_byte(ORIENT_LEN);
        put_byte(8'h00); put_byte(8'h80);      // heading most negative
        put_byte(8'hFF); put_byte(8'h7F);      // pitch most positive
        put_byte(8'hFF); put_byte(8'hFF);      // roll minus one
        drain();

        // random with idling on both sides
        tx_idle = 1'b1;
        rx_idle = 1'b1;
        run_random(60);
        drain();

        // no sender gaps; receiver holds off long so the parser backs up
        tx_idle  = 1'b0;
        hold_req = 1'b1;
        run_random(60);
        drain();

        // longest read once, then more random traffic with idling
        tx_idle = 1'b1;
        put_read(255);
        rx_idle = 1'b0;
        run_random(25);
        rx_idle = 1'b1;
        run_random(25);
        drain();

        if (sb.errors == 0 && sb.pending() == 0)
            $display("imu_uart_response_parser verification clean");
        else
            $display("imu_uart_response_parser verification failed");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("imu_uart_response_parser verification failed");
        $finish;
    end

endmodule
